>>> rtl/f64_to_f32_storage_error_stats_core_assert.svh
// Assertion macros shared by the storage error statistics core.
`ifndef F64_TO_F32_STORAGE_ERROR_STATS_CORE_ASSERT_SVH
`define F64_TO_F32_STORAGE_ERROR_STATS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSES_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fses assertion failed");

// Next-cycle implication, checked outside reset.
`define FSES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fses assertion failed");

`endif

>>> rtl/fses_pkg.sv
// Types and constants shared by the storage error statistics core.
package fses_pkg;

  typedef struct packed {
    logic [63:0] reference_bits;
    logic [1:0]  anchor_kind;
    logic        anchor_known;
    logic [63:0] anchor_value;
    logic        last_item;
  } item_word_t;

  typedef struct packed {
    logic [31:0] sample_total;
    logic [31:0] invalid_total;
    logic [31:0] nonfinite_total;
    logic [63:0] max_abs_error;
    logic [31:0] gaussian_total;
    logic [63:0] max_gaussian_ratio;
    logic [31:0] quantile_total;
    logic [63:0] max_quantile_ratio;
    logic [31:0] within_total;
    logic [31:0] outside_total;
  } stats_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_NORM,
    ST_DIV,
    ST_QNORM,
    ST_DENORM,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  localparam logic [1:0]  KIND_UNKNOWN = 2'd0;
  localparam logic [1:0]  KIND_GAUSS   = 2'd1;
  localparam logic [1:0]  KIND_P50     = 2'd2;
  localparam logic [1:0]  KIND_P95     = 2'd3;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] INF_BITS     = 64'h7FF0_0000_0000_0000;

  // Quotient bits produced: one integer bit, 52 fraction bits, guard and two more.
  localparam int unsigned QUOT_BITS = 56;

endpackage

>>> rtl/fses_div.sv
// Restoring mantissa divider producing one quotient bit per cycle.
module fses_div
  import fses_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [52:0]          dividend,
  input  logic [52:0]          divisor,
  output logic [QUOT_BITS-1:0] quotient,
  output logic                 sticky,
  output div_status_t          status
);

  logic [53:0]          rem;
  logic [52:0]          dvs;
  logic [QUOT_BITS-1:0] quo;
  logic [5:0]           cnt;
  logic                 busy;
  logic                 done;
  logic                 take;
  logic [53:0]          rem_next;

  // Partial remainder stays below twice the divisor, so 54 bits suffice.
  always_comb begin
    take     = rem >= {1'b0, dvs};
    rem_next = take ? rem - {1'b0, dvs} : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(QUOT_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend};
      dvs <= divisor;
      quo <= '0;
    end else if (busy) begin
      quo <= {quo[QUOT_BITS-2:0], take};
      rem <= {rem_next[52:0], 1'b0};
    end
  end

  assign quotient    = quo;
  assign sticky      = rem != 54'd0;
  assign status.busy = busy;
  assign status.done = done;

endmodule

>>> rtl/f64_to_f32_storage_error_stats_core.sv
// Top level of the double-to-single storage error statistics core.
// How to use this block:
// Input words arrive on item/item_valid and are taken at an edge where
// item_valid is high and item_stall is low. Each word carries a double
// reference, an uncertainty anchor and a last_item flag. The block handles
// one word at a time and holds item_stall high while it works on it.
// A word whose fields or limit are invalid, or whose single rounding
// overflows, goes from its checks straight to the statistics update, and so
// does a zero rounding error. A zero anchor skips the divider. Other words
// normalize the error and anchor mantissas, pass the bit-serial mantissa
// divider and, for subnormal ratios, a right shift before rounding. On a
// word with last_item set, a further state loads a statistics word into the
// output register stats/stats_valid and the running statistics clear.
// The output register holds its word while stats_stall is high; the block
// keeps taking input words meanwhile and only waits if a second statistics
// word is ready before the first one has been taken.
// The user writes the max_ratio register through max_ratio_we and
// max_ratio_wdata only while the block is idle; the block does not enforce
// this. Synchronous reset sets the limit to 1.0, clears all counters and
// maxima and empties the output register.
module f64_to_f32_storage_error_stats_core
  import fses_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  item_word_t  item,
  input  logic        item_valid,
  output logic        item_stall,
  output stats_word_t stats,
  output logic        stats_valid,
  input  logic        stats_stall,
  input  logic        max_ratio_we,
  input  logic [63:0] max_ratio_wdata
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  state_t state, state_next;

  logic [63:0] max_ratio;
  item_word_t  item_q;

  // Per-item working registers.
  logic               item_invalid;
  logic               item_nonfinite;
  logic [52:0]        err_m;
  logic signed [13:0] err_e;
  logic               err_sub;
  logic [63:0]        err_bits;
  logic [52:0]        anc_m;
  logic signed [13:0] anc_e;
  logic               anc_zero;
  logic [QUOT_BITS-1:0] q_x;
  logic               q_s;
  logic signed [13:0] q_e;
  logic [63:0]        ratio_bits;

  // Running statistics.
  logic [COUNT_WIDTH-1:0] cnt_samples, cnt_invalid, cnt_nonfinite;
  logic [COUNT_WIDTH-1:0] cnt_gauss, cnt_quant, cnt_within, cnt_outside;
  logic [63:0]            max_err, max_gauss, max_quant;

  // Divider interface.
  logic                 div_start;
  logic [QUOT_BITS-1:0] div_quo;
  logic                 div_sticky;
  div_status_t          div_stat;

  logic item_take;
  logic emit_load;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (c == CNT_MAX) ? c : c + COUNT_WIDTH'(1);
  endfunction

  assign item_take = item_valid && !item_stall;

  //--------------------------------------------------------------------------
  // Item checks and rounding of the reference to single precision.
  // The rounding error is an integer count of double ulps of the reference,
  // taken from the bits that single precision drops.
  //--------------------------------------------------------------------------
  logic [10:0]  ref_e;
  logic [52:0]  ref_big;
  logic [54:0]  ref_ext;
  logic [10:0]  s_wide;
  logic [5:0]   s;
  logic [53:0]  mask_s, mask_h;
  logic [53:0]  rem54, neg54;
  logic         guard_bit, lower_nz, lsb_bit, round_up;
  logic [52:0]  d_val;
  logic         prep_invalid, prep_overflow;
  logic         anc_ok, lim_ok, ref_finite;
  logic [10:0]  anc_field;

  always_comb begin
    ref_e   = item_q.reference_bits[62:52];
    ref_big = {1'b1, item_q.reference_bits[51:0]};
    ref_ext = {2'b00, ref_big};
    s_wide  = 11'd926 - ref_e;
    if (ref_e >= 11'd897) begin
      s = 6'd29;
    end else if (ref_e <= 11'd872) begin
      s = 6'd54;
    end else begin
      s = s_wide[5:0];
    end
    for (int i = 0; i < 54; i++) begin
      mask_s[i] = 6'(i) < s;
      mask_h[i] = 6'(i) < (s - 6'd1);
    end
    rem54     = {1'b0, ref_big} & mask_s;
    neg54     = (~rem54 + 54'd1) & mask_s;
    guard_bit = ref_ext[s - 6'd1];
    lsb_bit   = ref_ext[s];
    lower_nz  = |({1'b0, ref_big} & mask_h);
    round_up  = guard_bit && (lower_nz || lsb_bit);
    if (ref_e == 11'd0) begin
      d_val = {1'b0, item_q.reference_bits[51:0]};
    end else begin
      d_val = round_up ? neg54[52:0] : rem54[52:0];
    end

    ref_finite = ref_e != EXP_ALL_ONES;
    anc_ok     = (item_q.anchor_value[62:52] != EXP_ALL_ONES) &&
                 (!item_q.anchor_value[63] || item_q.anchor_value[62:0] == 63'd0);
    lim_ok     = (max_ratio[62:52] != EXP_ALL_ONES) &&
                 (!max_ratio[63] || max_ratio[62:0] == 63'd0);
    prep_invalid = !ref_finite || !item_q.anchor_known ||
                   item_q.anchor_kind == KIND_UNKNOWN || !anc_ok || !lim_ok;
    // Overflow when the exponent is past the single range, or the top
    // binade rounds up into the next one.
    prep_overflow = (ref_e > 11'd1150) ||
                    (ref_e == 11'd1150 && round_up && (&ref_big[52:29]));
    anc_field = item_q.anchor_value[62:52];
  end

  //--------------------------------------------------------------------------
  // Normalization of error and anchor mantissas, one bit per cycle each.
  //--------------------------------------------------------------------------
  logic        norm_done;
  logic [63:0] err_pack;

  always_comb begin
    norm_done = err_m[52] && (anc_zero || anc_m[52]);
    err_pack  = err_sub ? err_bits : {1'b0, err_e[10:0], err_m[51:0]};
  end

  //--------------------------------------------------------------------------
  // Rounding of the quotient to nearest, ties to even.
  //--------------------------------------------------------------------------
  logic [53:0]        rnd_sum;
  logic               rnd_up;
  logic signed [13:0] rnd_field;
  logic [63:0]        rnd_bits;

  always_comb begin
    rnd_up  = q_x[2] && (q_x[1] || q_x[0] || q_s || q_x[3]);
    rnd_sum = {1'b0, q_x[55:3]} + {53'd0, rnd_up};
    if (rnd_sum[53]) begin
      rnd_field = q_e + 14'sd1;
    end else if (rnd_sum[52]) begin
      rnd_field = q_e;
    end else begin
      rnd_field = 14'sd0;
    end
    if (rnd_field >= 14'sd2047) begin
      rnd_bits = INF_BITS;
    end else begin
      rnd_bits = {1'b0, rnd_field[10:0], rnd_sum[53] ? 52'd0 : rnd_sum[51:0]};
    end
  end

  //--------------------------------------------------------------------------
  // Sequencer.
  //--------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_take) state_next = ST_PREP;
      end
      ST_PREP: begin
        if (prep_invalid || prep_overflow || d_val == 53'd0) begin
          state_next = ST_UPDATE;
        end else begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_done) state_next = anc_zero ? ST_UPDATE : ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) state_next = ST_QNORM;
      end
      ST_QNORM:  state_next = ST_DENORM;
      ST_DENORM: begin
        if (q_e >= 14'sd1) state_next = ST_ROUND;
      end
      ST_ROUND:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = item_q.last_item ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (!stats_valid || !stats_stall) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    div_start  = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      ST_IDLE: item_stall = 1'b0;
      ST_NORM: div_start  = norm_done && !anc_zero;
      ST_EMIT: emit_load  = !stats_valid || !stats_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_ratio <= ONE_BITS;
    end else if (max_ratio_we) begin
      max_ratio <= max_ratio_wdata;
    end
  end

  // Working datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item_take) item_q <= item;
      end
      ST_PREP: begin
        item_invalid   <= prep_invalid;
        item_nonfinite <= !prep_invalid && prep_overflow;
        err_m          <= d_val;
        err_e          <= (ref_e == 11'd0) ? 14'sd1 : $signed({3'b000, ref_e});
        err_sub        <= 1'b0;
        err_bits       <= 64'd0;
        ratio_bits     <= 64'd0;
        anc_zero       <= item_q.anchor_value[62:0] == 63'd0;
        if (anc_field == 11'd0) begin
          anc_m <= {1'b0, item_q.anchor_value[51:0]};
          anc_e <= 14'sd1;
        end else begin
          anc_m <= {1'b1, item_q.anchor_value[51:0]};
          anc_e <= $signed({3'b000, anc_field});
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          err_bits <= err_pack;
          q_e      <= err_e - anc_e + 14'sd1023;
          if (anc_zero) ratio_bits <= INF_BITS;
        end else begin
          if (!err_m[52]) begin
            // The error drops below the normal range here: keep its
            // subnormal encoding before normalizing further.
            if (err_e == 14'sd1 && !err_sub) begin
              err_bits <= {12'd0, err_m[51:0]};
              err_sub  <= 1'b1;
            end
            err_m <= {err_m[51:0], 1'b0};
            err_e <= err_e - 14'sd1;
          end
          if (!anc_zero && !anc_m[52]) begin
            anc_m <= {anc_m[51:0], 1'b0};
            anc_e <= anc_e - 14'sd1;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          q_x <= div_quo;
          q_s <= div_sticky;
        end
      end
      ST_QNORM: begin
        if (!q_x[QUOT_BITS-1]) begin
          q_x <= {q_x[QUOT_BITS-2:0], 1'b0};
          q_e <= q_e - 14'sd1;
        end
      end
      ST_DENORM: begin
        if (q_e < -14'sd60) begin
          q_s <= q_s || (q_x != '0);
          q_x <= '0;
          q_e <= 14'sd1;
        end else if (q_e < 14'sd1) begin
          q_s <= q_s || q_x[0];
          q_x <= {1'b0, q_x[QUOT_BITS-1:1]};
          q_e <= q_e + 14'sd1;
        end
      end
      ST_ROUND: ratio_bits <= rnd_bits;
      default: ;
    endcase
  end

  // Running statistics and output register.
  always_ff @(posedge clk) begin
    if (rst || emit_load) begin
      cnt_samples   <= '0;
      cnt_invalid   <= '0;
      cnt_nonfinite <= '0;
      cnt_gauss     <= '0;
      cnt_quant     <= '0;
      cnt_within    <= '0;
      cnt_outside   <= '0;
      max_err       <= 64'd0;
      max_gauss     <= 64'd0;
      max_quant     <= 64'd0;
    end else if (state == ST_UPDATE) begin
      cnt_samples <= bump(cnt_samples);
      if (item_invalid) begin
        cnt_invalid <= bump(cnt_invalid);
      end else if (item_nonfinite) begin
        cnt_nonfinite <= bump(cnt_nonfinite);
      end else begin
        // Non-negative doubles order like their bit patterns.
        if (err_bits > max_err) max_err <= err_bits;
        if (item_q.anchor_kind == KIND_GAUSS) begin
          cnt_gauss <= bump(cnt_gauss);
          if (ratio_bits > max_gauss) max_gauss <= ratio_bits;
        end else begin
          cnt_quant <= bump(cnt_quant);
          if (ratio_bits > max_quant) max_quant <= ratio_bits;
        end
        // A negative-zero limit compares as zero.
        if (ratio_bits <= {1'b0, max_ratio[62:0]}) begin
          cnt_within <= bump(cnt_within);
        end else begin
          cnt_outside <= bump(cnt_outside);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats_valid <= 1'b0;
    end else if (emit_load) begin
      stats_valid <= 1'b1;
    end else if (!stats_stall) begin
      stats_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      stats.sample_total       <= 32'(cnt_samples);
      stats.invalid_total      <= 32'(cnt_invalid);
      stats.nonfinite_total    <= 32'(cnt_nonfinite);
      stats.max_abs_error      <= max_err;
      stats.gaussian_total     <= 32'(cnt_gauss);
      stats.max_gaussian_ratio <= max_gauss;
      stats.quantile_total     <= 32'(cnt_quant);
      stats.max_quantile_ratio <= max_quant;
      stats.within_total       <= 32'(cnt_within);
      stats.outside_total      <= 32'(cnt_outside);
    end
  end

  fses_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (err_m),
    .divisor  (anc_m),
    .quotient (div_quo),
    .sticky   (div_sticky),
    .status   (div_stat)
  );

  //--------------------------------------------------------------------------
  // Assertions.
  //--------------------------------------------------------------------------
`include "f64_to_f32_storage_error_stats_core_assert.svh"

  `FSES_ASSERT_NOW(a_div_done_in_div, div_stat.done, state == ST_DIV)
  `FSES_ASSERT_NEXT(a_take_goes_prep, item_take, state == ST_PREP)
  `FSES_ASSERT_NOW(a_round_exp_normal, state == ST_ROUND, q_e >= 14'sd1)
  `FSES_ASSERT_NOW(a_stats_rise_from_emit, $rose(stats_valid), $past(state) == ST_EMIT)

endmodule
